// ===== hdl/abts_pkg.sv =====
// ----------------------------------------------------------------------------
// abts_pkg: shared types and constants of the block transfer sequencer
// Status and PC action codes, the decoded descriptor that travels from the
// decoder to the sequencer, and the result item.
// ----------------------------------------------------------------------------
package abts_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int OFF_W      = PAGE_SHIFT + 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [31:0] BDT_MASK  = 32'h0e00_0000;
    localparam logic [31:0] BDT_MATCH = 32'h0800_0000;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOT_BDT = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_SBIT    = 3'd3,
        ST_BASE_PC = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PC_NONE   = 2'd0,
        PC_SYNC   = 2'd1,
        PC_BRANCH = 2'd2
    } t_pc_action;

    typedef struct packed {
        t_status     status;
        logic [15:0] regs;
        logic [3:0]  rn;
        logic        is_load;
        logic        wb;
        logic        up;
        logic [31:0] start;
        logic        fast;
        logic [31:0] wb_value;
    } t_desc;

    typedef struct packed {
        t_status     status;
        logic [3:0]  reg_index;
        logic [31:0] word_address;
        logic        is_load;
        logic        skip_transfer;
        logic        add_pc_offset;
        logic        fast_path;
        logic        writeback_en;
        logic [31:0] writeback_value;
        t_pc_action  pc_action;
        logic        last;
    } t_result;

endpackage

// ===== hdl/abts_front.sv =====
// ----------------------------------------------------------------------------
// abts_front: instruction decoder
// Classifies the instruction, counts the register list and works out the
// start address, writeback value and the within-page verdict.
// ----------------------------------------------------------------------------
module abts_front (
    input  logic [31:0]    i_instr_word,
    input  logic [31:0]    i_base_value,
    input  logic           i_page_present,
    output abts_pkg::t_desc o_desc
);
    import abts_pkg::*;

    logic [4:0]       n;
    logic [3:0]       rn;
    logic             pre, up, sbit, wb, ld;
    logic [31:0]      n4_32;
    logic [31:0]      start;
    logic [OFF_W-1:0] off, n4, psize, c4;
    logic             fits;
    t_status          status;

    always_comb begin
        n = '0;
        for (int i = 0; i < 16; i++) begin
            n = n + 5'(i_instr_word[i]);
        end
    end

    assign rn   = i_instr_word[19:16];
    assign pre  = i_instr_word[24];
    assign up   = i_instr_word[23];
    assign sbit = i_instr_word[22];
    assign wb   = i_instr_word[21];
    assign ld   = i_instr_word[20];

    assign n4_32 = {25'd0, n, 2'b00};
    assign n4    = OFF_W'({n, 2'b00});
    assign psize = OFF_W'(1) << PAGE_SHIFT;
    assign c4    = OFF_W'(4);

    always_comb begin
        start = i_base_value;
        if (pre) begin
            start = up ? i_base_value + 32'd4 : i_base_value - 32'd4;
        end
    end

    assign off = {1'b0, start[PAGE_SHIFT-1:2], 2'b00};

    always_comb begin
        unique case ({pre, up})
            2'b00:   fits = (n == 5'd1) || (off >= n4 - c4);
            2'b01:   fits = (n == 5'd1) || (off <= psize - n4);
            2'b10:   fits = off >= n4;
            default: fits = off <= psize - c4 - n4;
        endcase
    end

    // first failing check wins
    always_comb begin
        priority if ((i_instr_word & BDT_MASK) != BDT_MATCH) begin
            status = ST_NOT_BDT;
        end else if (n == 5'd0) begin
            status = ST_EMPTY;
        end else if (sbit) begin
            status = ST_SBIT;
        end else if (rn == 4'd15) begin
            status = ST_BASE_PC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_desc.status   = status;
        o_desc.regs     = i_instr_word[15:0];
        o_desc.rn       = rn;
        o_desc.is_load  = ld;
        o_desc.wb       = wb;
        o_desc.up       = up;
        o_desc.start    = start;
        o_desc.fast     = fits & i_page_present;
        o_desc.wb_value = '0;
        if (wb) begin
            o_desc.wb_value = up ? i_base_value + n4_32 : i_base_value - n4_32;
        end
    end

endmodule

// ===== hdl/abts_queue.sv =====
// ----------------------------------------------------------------------------
// abts_queue: descriptor queue
// Short FIFO of decoded instructions between the decoder and the sequencer.
// ----------------------------------------------------------------------------
module abts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abts_pkg::t_desc i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output abts_pkg::t_desc o_data
);
    import abts_pkg::*;

    t_desc           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

// ===== hdl/abts_back.sv =====
// ----------------------------------------------------------------------------
// abts_back: transfer sequencer
// Walks the register list of one descriptor, one transfer per cycle unless a
// stalled full output holds it, into a registered output stage.
// ----------------------------------------------------------------------------
module abts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  abts_pkg::t_desc   i_q_data,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output abts_pkg::t_result o_result
);
    import abts_pkg::*;

    function automatic logic [3:0] lowest(input logic [15:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

    function automatic logic [3:0] highest(input logic [15:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) r = 4'(i);
        end
        return r;
    endfunction

    logic        r_busy;
    t_desc       r_d;
    logic [15:0] r_mask;
    logic [31:0] r_addr;
    logic        r_ov;
    t_result     r_res;

    logic        emit, is_err, fin;
    logic [3:0]  idx;
    logic [15:0] rem;
    t_result     n_res;

    assign o_pop  = !r_busy && i_q_valid;
    assign emit   = r_busy && (!r_ov || !i_stall);
    assign idx    = r_d.up ? lowest(r_mask) : highest(r_mask);
    assign rem    = r_mask & ~(16'd1 << idx);
    assign is_err = r_d.status != ST_OK;
    assign fin    = is_err || (rem == '0);

    always_comb begin
        n_res        = '0;
        n_res.status = r_d.status;
        n_res.last   = fin;
        if (!is_err) begin
            n_res.reg_index     = idx;
            n_res.word_address  = r_addr;
            n_res.is_load       = r_d.is_load;
            n_res.skip_transfer = r_d.is_load && r_d.wb && (idx == r_d.rn);
            n_res.add_pc_offset = !r_d.is_load && (idx == 4'd15);
            if (fin) begin
                n_res.fast_path       = r_d.fast;
                n_res.writeback_en    = r_d.wb;
                n_res.writeback_value = r_d.wb_value;
                if (r_d.regs[15]) begin
                    n_res.pc_action = r_d.is_load ? PC_BRANCH : PC_SYNC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_d    <= i_q_data;
            r_mask <= i_q_data.regs;
            r_addr <= i_q_data.start;
        end else if (emit) begin
            r_mask <= rem;
            r_addr <= r_d.up ? r_addr + 32'd4 : r_addr - 32'd4;
        end
        if (emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && fin) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

// ===== hdl/arm_block_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// arm_block_transfer_sequencer: load/store multiple transfer sequencer
// Turns one LDM/STM instruction into a stream of per-register transfers.
// ----------------------------------------------------------------------------
// An accepted instruction is decoded straight into a two-entry queue, so up
// to two further instructions are taken while the sequencer is busy. The
// sequencer first loads a queued instruction and then walks its register
// list through the output register, one item per listed register (a single
// item for an error result); it takes the next instruction only once the
// last item of the current one has been emitted.
// Output holds under stall; the last item of an instruction carries
// writeback, the fast-path verdict and the PC action.
module arm_block_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_base_value,
    input  logic        i_page_present,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_reg_index,
    output logic [31:0] o_word_address,
    output logic        o_is_load,
    output logic        o_skip_transfer,
    output logic        o_add_pc_offset,
    output logic        o_fast_path,
    output logic        o_writeback_en,
    output logic [31:0] o_writeback_value,
    output logic [1:0]  o_pc_action,
    output logic        o_last
);
    import abts_pkg::*;

    t_desc   dec_desc, q_desc;
    logic    q_full, q_valid, q_pop, push;
    t_result res;

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    abts_front u_front (
        .i_instr_word   (i_instr_word),
        .i_base_value   (i_base_value),
        .i_page_present (i_page_present),
        .o_desc         (dec_desc)
    );

    abts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_desc)
    );

    abts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_desc),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_result  (res)
    );

    assign o_status          = res.status;
    assign o_reg_index       = res.reg_index;
    assign o_word_address    = res.word_address;
    assign o_is_load         = res.is_load;
    assign o_skip_transfer   = res.skip_transfer;
    assign o_add_pc_offset   = res.add_pc_offset;
    assign o_fast_path       = res.fast_path;
    assign o_writeback_en    = res.writeback_en;
    assign o_writeback_value = res.writeback_value;
    assign o_pc_action       = res.pc_action;
    assign o_last            = res.last;

endmodule

// ===== hdl/abts_checker.sv =====
// ----------------------------------------------------------------------------
// abts_checker: port-level checks of the block transfer sequencer
// Watches the output channel and the shape of each result item.
// ----------------------------------------------------------------------------
module abts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [3:0]  o_reg_index,
    input logic [31:0] o_word_address,
    input logic        o_is_load,
    input logic        o_skip_transfer,
    input logic        o_fast_path,
    input logic        o_writeback_en,
    input logic [1:0]  o_pc_action,
    input logic        o_last
);
    import abts_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_address)
            && $stable(o_reg_index) && $stable(o_last))
        else $error("stalled output item changed");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            o_last && (o_reg_index == '0) && (o_word_address == '0) && !o_is_load)
        else $error("error item is not a lone cleared item");

    a_tail_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |->
            !o_fast_path && !o_writeback_en && (o_pc_action == PC_NONE))
        else $error("instruction summary on a non-final item");

    a_skip_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_skip_transfer |-> o_is_load && o_writeback_en == o_last ||
            o_is_load && !o_last)
        else $error("skip mark on a store");

endmodule

bind arm_block_transfer_sequencer abts_checker u_abts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_reg_index    (o_reg_index),
    .o_word_address (o_word_address),
    .o_is_load      (o_is_load),
    .o_skip_transfer(o_skip_transfer),
    .o_fast_path    (o_fast_path),
    .o_writeback_en (o_writeback_en),
    .o_pc_action    (o_pc_action),
    .o_last         (o_last)
);

// ===== dv/arm_block_transfer_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_block_transfer_sequencer_tb: self-checking bench for the LDM/STM sequencer
// Drives load/store multiple instructions with random idling and stalls on both
// channels and predicts every transfer, including the writeback, fast-path and
// PC action on the last one. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module arm_block_transfer_sequencer_tb;

    import abts_pkg::*;

    class transfer_scoreboard;

        t_result expected_transfers[$];
        int      mismatches = 0;

        task report(string what);
            mismatches++;
            $display("%0t: mismatch: %s", $time, what);
        endtask

        // Expand one instruction into the transfers it should produce.
        function void note_instruction(logic [31:0] iw, logic [31:0] base, logic pg);
            localparam logic [31:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT;
            t_result     r;
            t_status     st;
            logic [3:0]  rn;
            logic        pre, up, ld, wb;
            int          n, slot, idx;
            logic [31:0] start, off;
            logic        fits;

            rn  = iw[19:16];
            pre = iw[24];
            up  = iw[23];
            wb  = iw[21];
            ld  = iw[20];
            n   = $countones(iw[15:0]);

            if ((iw & BDT_MASK) != BDT_MATCH)
                st = ST_NOT_BDT;
            else if (n == 0)
                st = ST_EMPTY;
            else if (iw[22])
                st = ST_SBIT;
            else if (rn == 4'd15)
                st = ST_BASE_PC;
            else
                st = ST_OK;

            if (st != ST_OK) begin
                r        = '0;
                r.status = st;
                r.last   = 1'b1;
                expected_transfers.push_back(r);
                return;
            end

            start = base;
            if (pre)
                start = up ? base + 32'd4 : base - 32'd4;
            off = start & (PAGE_BYTES - 32'd4);

            case ({pre, up})
                2'b00: fits = (n <= 1) || (off >= 32'(4 * (n - 1)));
                2'b01: fits = (n <= 1) || (off <= PAGE_BYTES - 32'(4 * n));
                2'b10: fits = off >= 32'(4 * n);
                default: fits = off <= PAGE_BYTES - 32'd4 - 32'(4 * n);
            endcase

            slot = 0;
            for (int k = 0; k < 16; k++) begin
                idx = up ? k : 15 - k;
                if (iw[idx]) begin
                    r                 = '0;
                    r.status          = ST_OK;
                    r.reg_index       = 4'(idx);
                    r.word_address    = up ? start + 32'(4 * slot) : start - 32'(4 * slot);
                    r.is_load         = ld;
                    r.skip_transfer   = ld && wb && (4'(idx) == rn);
                    r.add_pc_offset   = !ld && (idx == 15);
                    r.pc_action       = PC_NONE;
                    slot++;
                    if (slot == n) begin
                        r.fast_path    = fits && pg;
                        r.writeback_en = wb;
                        if (wb)
                            r.writeback_value = up ? base + 32'(4 * n) : base - 32'(4 * n);
                        if (iw[15])
                            r.pc_action = ld ? PC_BRANCH : PC_SYNC;
                        r.last = 1'b1;
                    end
                    expected_transfers.push_back(r);
                end
            end
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_transfer(t_result got);
            t_result want;
            if (expected_transfers.size() == 0) begin
                report("transfer with no instruction pending");
                return;
            end
            want = expected_transfers.pop_front();
            check_field("status",          32'(got.status),          32'(want.status));
            check_field("reg_index",       32'(got.reg_index),       32'(want.reg_index));
            check_field("word_address",    got.word_address,         want.word_address);
            check_field("is_load",         32'(got.is_load),         32'(want.is_load));
            check_field("skip_transfer",   32'(got.skip_transfer),   32'(want.skip_transfer));
            check_field("add_pc_offset",   32'(got.add_pc_offset),   32'(want.add_pc_offset));
            check_field("fast_path",       32'(got.fast_path),       32'(want.fast_path));
            check_field("writeback_en",    32'(got.writeback_en),    32'(want.writeback_en));
            check_field("writeback_value", got.writeback_value,      want.writeback_value);
            check_field("pc_action",       32'(got.pc_action),       32'(want.pc_action));
            check_field("last",            32'(got.last),            32'(want.last));
        endtask

    endclass

    localparam int          CYCLE_LIMIT   = 400_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 330;
    localparam logic [31:0] PAGE_BYTES    = 32'd1 << PAGE_SHIFT;
    localparam logic [31:0] PAGE_A        = 32'h0001_0000;
    localparam logic [31:0] PAGE_B        = 32'h0002_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_instr_word;
    logic [31:0] i_base_value;
    logic        i_page_present;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_reg_index;
    logic [31:0] o_word_address;
    logic        o_is_load;
    logic        o_skip_transfer;
    logic        o_add_pc_offset;
    logic        o_fast_path;
    logic        o_writeback_en;
    logic [31:0] o_writeback_value;
    logic [1:0]  o_pc_action;
    logic        o_last;

    transfer_scoreboard sb = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_off_req    = 1'b0;
    int cycle_count     = 0;

    arm_block_transfer_sequencer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_instr_word      (i_instr_word),
        .i_base_value      (i_base_value),
        .i_page_present    (i_page_present),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_reg_index       (o_reg_index),
        .o_word_address    (o_word_address),
        .o_is_load         (o_is_load),
        .o_skip_transfer   (o_skip_transfer),
        .o_add_pc_offset   (o_add_pc_offset),
        .o_fast_path       (o_fast_path),
        .o_writeback_en    (o_writeback_en),
        .o_writeback_value (o_writeback_value),
        .o_pc_action       (o_pc_action),
        .o_last            (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Take every accepted transfer off the output channel.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status          = t_status'(o_status);
            got.reg_index       = o_reg_index;
            got.word_address    = o_word_address;
            got.is_load         = o_is_load;
            got.skip_transfer   = o_skip_transfer;
            got.add_pc_offset   = o_add_pc_offset;
            got.fast_path       = o_fast_path;
            got.writeback_en    = o_writeback_en;
            got.writeback_value = o_writeback_value;
            got.pc_action       = t_pc_action'(o_pc_action);
            got.last            = o_last;
            sb.check_transfer(got);
        end
    end

    // Receiver: random stalls, or a long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic logic [31:0] bdt_word(logic p, logic u, logic s, logic w, logic l,
                                             logic [3:0] rn, logic [15:0] regs);
        bdt_word = {4'($urandom), 3'b100, p, u, s, w, l, rn, regs};
    endfunction

    function automatic logic [15:0] random_regs();
        case ($urandom_range(7))
            0, 1: random_regs = 16'd1 << $urandom_range(15);
            2, 3: random_regs = 16'($urandom);
            4:    random_regs = 16'($urandom) & 16'($urandom);
            5:    random_regs = 16'($urandom) | 16'($urandom);
            6:    random_regs = 16'hffff;
            default: random_regs = 16'($urandom) | 16'h8000;
        endcase
    endfunction

    // Bias bases towards page edges and the ends of the address space.
    function automatic logic [31:0] random_base();
        case ($urandom_range(4))
            0: random_base = $urandom;
            1: random_base = ($urandom & ~(PAGE_BYTES - 1)) | $urandom_range(80);
            2: random_base = ($urandom & ~(PAGE_BYTES - 1)) | (PAGE_BYTES - 1 - $urandom_range(80));
            3: random_base = 32'hffff_ffff - $urandom_range(80);
            default: random_base = $urandom_range(80);
        endcase
    endfunction

    // Entered and left at a falling edge; holds the item until it is taken.
    task automatic send_item(logic [31:0] iw, logic [31:0] base, logic pg);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_instr_word   <= iw;
        i_base_value   <= base;
        i_page_present <= pg;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_instruction(iw, base, pg);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic [31:0] iw;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 85)
            iw = bdt_word(1'($urandom), 1'($urandom), $urandom_range(9) == 0,
                          1'($urandom), 1'($urandom), 4'($urandom), random_regs());
        else if (kind < 93)
            iw = $urandom;
        else
            iw = bdt_word(1'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom), 4'($urandom), 16'h0000);
        send_item(iw, random_base(), 1'($urandom));
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_instr_word   = '0;
        i_base_value   = '0;
        i_page_present = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Encoding errors and their priority
        send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_item(bdt_word(0, 1, 0, 0, 1, 4'd2, 16'h0000), PAGE_A, 1'b1);
        send_item(bdt_word(1, 1, 1, 0, 0, 4'd2, 16'h00f0), PAGE_A, 1'b1);
        send_item(bdt_word(0, 0, 0, 1, 1, 4'd15, 16'h0003), PAGE_A, 1'b1);
        send_item(bdt_word(1, 0, 1, 1, 0, 4'd15, 16'h0000), PAGE_A, 1'b1);
        send_item(bdt_word(0, 1, 1, 0, 1, 4'd15, 16'h0100), PAGE_A, 1'b1);

        // All four addressing modes with the full list, mid-page
        send_item(bdt_word(0, 0, 0, 1, 1, 4'd0, 16'hffff), PAGE_A + 32'h200, 1'b1);
        send_item(bdt_word(0, 1, 0, 1, 0, 4'd1, 16'hffff), PAGE_A + 32'h200, 1'b1);
        send_item(bdt_word(1, 0, 0, 1, 0, 4'd13, 16'hffff), PAGE_A + 32'h200, 1'b1);
        send_item(bdt_word(1, 1, 0, 1, 1, 4'd14, 16'hffff), PAGE_A + 32'h200, 1'b1);

        // Single registers right at the page edges
        send_item(bdt_word(0, 0, 0, 0, 1, 4'd4, 16'h0010), PAGE_A, 1'b1);
        send_item(bdt_word(0, 1, 0, 0, 0, 4'd4, 16'h0001), PAGE_B - 32'd4, 1'b1);
        send_item(bdt_word(1, 0, 0, 0, 1, 4'd4, 16'h4000), PAGE_A, 1'b1);
        send_item(bdt_word(1, 1, 0, 0, 0, 4'd4, 16'h0002), PAGE_B - 32'd4, 1'b1);

        // Loaded base under writeback, stored and loaded PC
        send_item(bdt_word(0, 1, 0, 1, 1, 4'd3, 16'h001c), PAGE_A + 32'h40, 1'b1);
        send_item(bdt_word(1, 0, 0, 1, 0, 4'd13, 16'h8003), PAGE_A + 32'h40, 1'b1);
        send_item(bdt_word(0, 1, 0, 1, 1, 4'd13, 16'h8001), PAGE_A + 32'h40, 1'b1);

        // Address wrap both ways, and an unmapped page
        send_item(bdt_word(0, 1, 0, 1, 1, 4'd5, 16'hffff), 32'hffff_fff8, 1'b1);
        send_item(bdt_word(1, 0, 0, 1, 0, 4'd5, 16'hffff), 32'h0000_0004, 1'b1);
        send_item(bdt_word(0, 1, 0, 0, 0, 4'd6, 16'h0f00), PAGE_A + 32'h100, 1'b0);

        // Page-bound tests just inside and just outside
        send_item(bdt_word(1, 1, 0, 0, 1, 4'd7, 16'h000f), PAGE_A + PAGE_BYTES - 32'd24, 1'b1);
        send_item(bdt_word(1, 1, 0, 0, 1, 4'd7, 16'h000f), PAGE_A + PAGE_BYTES - 32'd20, 1'b1);
        send_item(bdt_word(0, 0, 0, 0, 0, 4'd8, 16'h000f), PAGE_B + 32'd12, 1'b1);
        send_item(bdt_word(0, 0, 0, 0, 0, 4'd8, 16'h000f), PAGE_B + 32'd8, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i / 66)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin sender_idle_pct = 33; recv_stall_pct = 33; end
                default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // Hold the receiver off while the sender keeps offering items.
            if (i == 4 * 66)
                hold_off_req = 1'b1;
            send_random_item();
        end
        i_in_valid <= 1'b0;

        while (sb.expected_transfers.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_transfers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
